### rtl/scr_pkg.sv
package scr_pkg;

   localparam int CHANNEL_BITS     = 8;
   localparam int LINEAR_FRAC_BITS = 16;
   localparam int RATIO_FRAC_BITS  = 11;

   localparam int CH_COUNT = 1 << CHANNEL_BITS;
   localparam int CH_MAX   = CH_COUNT - 1;
   localparam int NUM_CH   = 6;

   localparam int LIN_W    = LINEAR_FRAC_BITS + 1;
   localparam int PROD_W   = LINEAR_FRAC_BITS + 13;
   localparam int LUMA_W   = LINEAR_FRAC_BITS + 14;
   localparam int INT_BITS = 5;
   localparam int QUOT_W   = INT_BITS + RATIO_FRAC_BITS;
   localparam int RATIO_W  = 16;
   localparam int SAT_W    = QUOT_W + RATIO_W;

   localparam int unsigned LIN_DEN = 1292 * CH_MAX;
   localparam int unsigned POW_DEN = 1055 * CH_MAX;

   localparam logic [PROD_W-1:0] WEIGHT_R = PROD_W'(2126);
   localparam logic [PROD_W-1:0] WEIGHT_G = PROD_W'(7152);
   localparam logic [PROD_W-1:0] WEIGHT_B = PROD_W'(722);

   localparam logic [LUMA_W-1:0] LUMA_OFFSET = LUMA_W'(500) << LINEAR_FRAC_BITS;
   localparam logic [QUOT_W-1:0] RATIO_ONE   = QUOT_W'(1) << RATIO_FRAC_BITS;
   localparam logic [RATIO_W-1:0] RATIO_MAX  = {RATIO_W{1'b1}};

   localparam logic [63:0] Q30_ONE = 64'd1 << 30;

   typedef logic [LIN_W-1:0] lin_table_type [CH_COUNT];

   typedef struct packed {
      logic              valid;
      logic [LUMA_W-1:0] rem;
      logic [LUMA_W-1:0] den;
      logic [QUOT_W-1:0] bits;
      logic [QUOT_W-1:0] quot;
   } div_stage_type;

   function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] p;
      p = a * b;
      return p >> 30;
   endfunction

   function automatic logic [63:0] q30_pow5(input logic [63:0] y);
      logic [63:0] p;
      p = q30_mul(y, y);
      p = q30_mul(p, y);
      p = q30_mul(p, y);
      return q30_mul(p, y);
   endfunction

   // The transfer curve is evaluated once, while the design is elaborated.
   function automatic lin_table_type build_lin_table();
      lin_table_type tab;
      logic [63:0]   c;
      logic [63:0]   t;
      logic [63:0]   s;
      logic [63:0]   lo;
      logic [63:0]   hi;
      logic [63:0]   mid;
      logic [63:0]   p;
      logic [63:0]   num;
      for (int i = 0; i < CH_COUNT; i++) begin
         c = 64'(i);
         if (c * 64'd100000 <= 64'(4045 * CH_MAX)) begin
            num = ((64'd100 * c) << LINEAR_FRAC_BITS) + 64'(LIN_DEN / 2);
            num = num / LIN_DEN;
            tab[i] = num[LIN_W-1:0];
         end else begin
            t  = ((64'd1000 * c + 64'(55 * CH_MAX)) << 30) / POW_DEN;
            s  = q30_mul(t, t);
            lo = 64'd0;
            hi = Q30_ONE;
            for (int k = 0; k < 32; k++) begin
               if (lo < hi) begin
                  mid = (lo + hi + 64'd1) >> 1;
                  if (q30_pow5(mid) <= s) begin
                     lo = mid;
                  end else begin
                     hi = mid - 64'd1;
                  end
               end
            end
            p   = q30_mul(s, lo);
            num = (p + (64'd1 << (29 - LINEAR_FRAC_BITS))) >> (30 - LINEAR_FRAC_BITS);
            tab[i] = num[LIN_W-1:0];
         end
      end
      return tab;
   endfunction

   localparam lin_table_type LIN_TABLE = build_lin_table();

endpackage

### rtl/srgb_contrast_ratio.sv
// Channel   Direction  Handshake            Payload
// request   in         start high, busy low six 8-bit sRGB channels
// response  out        rsp_strobe, 1 cycle  rsp_ratio, 16 bits, 11 fraction bits
//
// One request is taken every cycle.
// The stages are the table lookup, weight multiply and sum stages, one select stage,
// one restoring-divider stage per quotient bit (16), and the output register.
// busy is high only while reset is asserted; reset clears every valid bit.
// The receiver cannot stall, so the pipeline never holds and no request waits.
module srgb_contrast_ratio
   import scr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [7:0]         req_first_red,
   input  logic [7:0]         req_first_green,
   input  logic [7:0]         req_first_blue,
   input  logic [7:0]         req_second_red,
   input  logic [7:0]         req_second_green,
   input  logic [7:0]         req_second_blue,
   output logic               rsp_strobe,
   output logic [RATIO_W-1:0] rsp_ratio
);

   logic                    accept;
   logic [CHANNEL_BITS-1:0] chan [NUM_CH];
   logic                    luma_valid;
   logic [LUMA_W-1:0]       luma_a;
   logic [LUMA_W-1:0]       luma_b;

   assign busy   = reset;
   assign accept = start & ~busy;

   assign chan[0] = req_first_red[CHANNEL_BITS-1:0];
   assign chan[1] = req_first_green[CHANNEL_BITS-1:0];
   assign chan[2] = req_first_blue[CHANNEL_BITS-1:0];
   assign chan[3] = req_second_red[CHANNEL_BITS-1:0];
   assign chan[4] = req_second_green[CHANNEL_BITS-1:0];
   assign chan[5] = req_second_blue[CHANNEL_BITS-1:0];

   scr_luma u_luma (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .chan       (chan),
      .luma_valid (luma_valid),
      .luma_a     (luma_a),
      .luma_b     (luma_b)
   );

   scr_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .luma_valid (luma_valid),
      .luma_a     (luma_a),
      .luma_b     (luma_b),
      .out_valid  (rsp_strobe),
      .ratio      (rsp_ratio)
   );

endmodule

### rtl/scr_luma.sv
module scr_luma
   import scr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [CHANNEL_BITS-1:0] chan [NUM_CH],
   output logic                    luma_valid,
   output logic [LUMA_W-1:0]       luma_a,
   output logic [LUMA_W-1:0]       luma_b
);

   localparam logic [PROD_W-1:0] WEIGHTS [NUM_CH] =
      '{WEIGHT_R, WEIGHT_G, WEIGHT_B, WEIGHT_R, WEIGHT_G, WEIGHT_B};

   logic              lin_valid_ff;
   logic              prod_valid_ff;
   logic              luma_valid_ff;
   logic [LIN_W-1:0]  lin_ff  [NUM_CH];
   logic [LIN_W-1:0]  lin_in  [NUM_CH];
   logic [PROD_W-1:0] prod_ff [NUM_CH];
   logic [PROD_W-1:0] prod_in [NUM_CH];
   logic [LUMA_W-1:0] luma_a_ff;
   logic [LUMA_W-1:0] luma_b_ff;
   logic [LUMA_W-1:0] luma_a_in;
   logic [LUMA_W-1:0] luma_b_in;

   always_comb begin
      for (int i = 0; i < NUM_CH; i++) begin
         lin_in[i]  = LIN_TABLE[chan[i]];
         prod_in[i] = PROD_W'(lin_ff[i]) * WEIGHTS[i];
      end
      luma_a_in = LUMA_W'(prod_ff[0]) + LUMA_W'(prod_ff[1]) + LUMA_W'(prod_ff[2]);
      luma_b_in = LUMA_W'(prod_ff[3]) + LUMA_W'(prod_ff[4]) + LUMA_W'(prod_ff[5]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lin_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         luma_valid_ff <= 1'b0;
      end else begin
         lin_valid_ff  <= in_valid;
         prod_valid_ff <= lin_valid_ff;
         luma_valid_ff <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      lin_ff    <= lin_in;
      prod_ff   <= prod_in;
      luma_a_ff <= luma_a_in;
      luma_b_ff <= luma_b_in;
   end

   assign luma_valid = luma_valid_ff;
   assign luma_a     = luma_a_ff;
   assign luma_b     = luma_b_ff;

endmodule

### rtl/scr_div_step.sv
module scr_div_step
   import scr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  div_stage_type stage_cur,
   output div_stage_type stage_nxt
);

   div_stage_type     stage_ff;
   div_stage_type     stage_in;
   logic [LUMA_W:0]   trial;
   logic [LUMA_W:0]   diff;
   logic              qbit;

   always_comb begin
      trial    = {stage_cur.rem, stage_cur.bits[QUOT_W-1]};
      diff     = trial - {1'b0, stage_cur.den};
      qbit     = (trial >= {1'b0, stage_cur.den});
      stage_in = stage_cur;
      stage_in.rem  = qbit ? diff[LUMA_W-1:0] : trial[LUMA_W-1:0];
      stage_in.bits = {stage_cur.bits[QUOT_W-2:0], 1'b0};
      stage_in.quot = {stage_cur.quot[QUOT_W-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign stage_nxt = stage_ff;

endmodule

### rtl/scr_divider.sv
module scr_divider
   import scr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               luma_valid,
   input  logic [LUMA_W-1:0]  luma_a,
   input  logic [LUMA_W-1:0]  luma_b,
   output logic               out_valid,
   output logic [RATIO_W-1:0] ratio
);

   logic               entry_valid_ff;
   logic [LUMA_W-1:0]  num_ff;
   logic [LUMA_W-1:0]  den_ff;
   logic [LUMA_W-1:0]  num_in;
   logic [LUMA_W-1:0]  den_in;
   div_stage_type      stage [QUOT_W+1];
   logic               out_valid_ff;
   logic [RATIO_W-1:0] ratio_ff;
   logic [RATIO_W-1:0] ratio_in;
   logic [SAT_W-1:0]   quot_wide;

   always_comb begin
      if (luma_a > luma_b) begin
         num_in = luma_a + LUMA_OFFSET;
         den_in = luma_b + LUMA_OFFSET;
      end else begin
         num_in = luma_b + LUMA_OFFSET;
         den_in = luma_a + LUMA_OFFSET;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else begin
         entry_valid_ff <= luma_valid;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
   end

   // The quotient stays below 32, so the top bits of the scaled dividend start below the divisor.
   always_comb begin
      stage[0].valid = entry_valid_ff;
      stage[0].rem   = LUMA_W'(num_ff >> INT_BITS);
      stage[0].den   = den_ff;
      stage[0].bits  = {num_ff[INT_BITS-1:0], RATIO_FRAC_BITS'(0)};
      stage[0].quot  = '0;
   end

   for (genvar g = 0; g < QUOT_W; g++) begin : g_step
      scr_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .stage_cur (stage[g]),
         .stage_nxt (stage[g+1])
      );
   end

   always_comb begin
      quot_wide = SAT_W'(stage[QUOT_W].quot);
      if (quot_wide > SAT_W'(RATIO_MAX)) begin
         ratio_in = RATIO_MAX;
      end else begin
         ratio_in = quot_wide[RATIO_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= stage[QUOT_W].valid;
      end
   end

   always_ff @(posedge clock) begin
      ratio_ff <= ratio_in;
   end

   assign out_valid = out_valid_ff;
   assign ratio     = ratio_ff;

   a_entry_order: assert property (@(posedge clock) disable iff (reset)
      entry_valid_ff |-> (den_ff <= num_ff))
      else $error("divisor exceeds dividend at divider entry");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      stage[QUOT_W].valid |-> (stage[QUOT_W].rem < stage[QUOT_W].den))
      else $error("final remainder not below divisor");

   a_ratio_floor: assert property (@(posedge clock) disable iff (reset)
      stage[QUOT_W].valid |=> (SAT_W'(ratio_ff) >= SAT_W'(RATIO_ONE)))
      else $error("ratio below one");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top
   import scr_pkg::*;
();

   localparam int NUM_RANDOM   = 1800;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [7:0] first_red;
      logic [7:0] first_green;
      logic [7:0] first_blue;
      logic [7:0] second_red;
      logic [7:0] second_green;
      logic [7:0] second_blue;
   } color_pair_type;

   typedef enum int unsigned {
      SPAN_FULL,
      SPAN_EDGE,
      SPAN_KNEE
   } span_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [7:0]         req_first_red    = 8'd0;
   logic [7:0]         req_first_green  = 8'd0;
   logic [7:0]         req_first_blue   = 8'd0;
   logic [7:0]         req_second_red   = 8'd0;
   logic [7:0]         req_second_green = 8'd0;
   logic [7:0]         req_second_blue  = 8'd0;
   logic               rsp_strobe;
   logic [RATIO_W-1:0] rsp_ratio;

   logic [LIN_W-1:0]   lin_curve [CH_COUNT];
   color_pair_type     pending_q [$];
   logic [RATIO_W-1:0] ratio_q [$];
   logic [RATIO_W-1:0] due_ratio;
   int unsigned        gap_left    = 0;
   int unsigned        steady_left = 0;
   int unsigned        idle_cycles = 0;
   bit                 mismatch_seen = 1'b0;

   srgb_contrast_ratio dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_first_red    (req_first_red),
      .req_first_green  (req_first_green),
      .req_first_blue   (req_first_blue),
      .req_second_red   (req_second_red),
      .req_second_green (req_second_green),
      .req_second_blue  (req_second_blue),
      .rsp_strobe       (rsp_strobe),
      .rsp_ratio        (rsp_ratio)
   );

   function automatic longint unsigned q30_product(longint unsigned a, longint unsigned b);
      return (a * b) >> 30;
   endfunction

   // Linear light of one encoded channel code on the sRGB transfer curve.
   function automatic logic [LIN_W-1:0] linear_level(int unsigned code);
      longint unsigned m;
      longint unsigned c;
      longint unsigned den;
      longint unsigned num;
      longint unsigned t;
      longint unsigned s;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      longint unsigned pw;
      longint unsigned p;
      m = CH_MAX;
      c = code;
      if (c * 100000 <= 4045 * m) begin
         den = 1292 * m;
         num = ((100 * c) << LINEAR_FRAC_BITS) + den / 2;
         return LIN_W'(num / den);
      end
      t  = ((1000 * c + 55 * m) << 30) / (1055 * m);
      s  = q30_product(t, t);
      lo = 0;
      hi = 64'd1 << 30;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         pw  = q30_product(mid, mid);
         pw  = q30_product(pw, mid);
         pw  = q30_product(pw, mid);
         pw  = q30_product(pw, mid);
         if (pw <= s) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      p = q30_product(s, lo);
      return LIN_W'((p + (64'd1 << (29 - LINEAR_FRAC_BITS))) >> (30 - LINEAR_FRAC_BITS));
   endfunction

   function automatic longint unsigned luminance(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      return 64'(2126) * lin_curve[r] + 64'(7152) * lin_curve[g] + 64'(722) * lin_curve[b];
   endfunction

   function automatic logic [RATIO_W-1:0] contrast_of(color_pair_type pair);
      longint unsigned la;
      longint unsigned lb;
      longint unsigned bright;
      longint unsigned dark;
      longint unsigned offset;
      longint unsigned q;
      la     = luminance(pair.first_red, pair.first_green, pair.first_blue);
      lb     = luminance(pair.second_red, pair.second_green, pair.second_blue);
      bright = (la > lb) ? la : lb;
      dark   = (la > lb) ? lb : la;
      offset = 64'd500 << LINEAR_FRAC_BITS;
      q      = ((bright + offset) << RATIO_FRAC_BITS) / (dark + offset);
      if (q > 64'hFFFF) begin
         q = 64'hFFFF;
      end
      return RATIO_W'(q);
   endfunction

   function automatic logic [7:0] pick_channel(span_type span);
      case (span)
         SPAN_EDGE: begin
            return $urandom_range(0, 1) ? 8'($urandom_range(252, 255)) : 8'($urandom_range(0, 3));
         end
         SPAN_KNEE: begin
            return 8'($urandom_range(8, 14));
         end
         default: begin
            return 8'($urandom());
         end
      endcase
   endfunction

   task automatic add_pair(input logic [7:0] r1, input logic [7:0] g1, input logic [7:0] b1,
                           input logic [7:0] r2, input logic [7:0] g2, input logic [7:0] b2);
      pending_q.push_back('{r1, g1, b1, r2, g2, b2});
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         gap_left <= 0;
      end else begin
         if (start && !busy) begin
            ratio_q.push_back(contrast_of('{req_first_red, req_first_green, req_first_blue,
                                            req_second_red, req_second_green,
                                            req_second_blue}));
         end
         if (!start || !busy) begin
            if (gap_left != 0) begin
               start    <= 1'b0;
               gap_left <= gap_left - 1;
            end else if (pending_q.size() != 0) begin
               req_first_red    <= pending_q[0].first_red;
               req_first_green  <= pending_q[0].first_green;
               req_first_blue   <= pending_q[0].first_blue;
               req_second_red   <= pending_q[0].second_red;
               req_second_green <= pending_q[0].second_green;
               req_second_blue  <= pending_q[0].second_blue;
               void'(pending_q.pop_front());
               start <= 1'b1;
               if (steady_left != 0) begin
                  steady_left <= steady_left - 1;
                  gap_left    <= 0;
               end else if ($urandom_range(0, 24) == 0) begin
                  steady_left <= $urandom_range(10, 60);
                  gap_left    <= 0;
               end else begin
                  gap_left <= $urandom_range(0, 6);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((start && !busy) || rsp_strobe !== 1'b0) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (rsp_strobe !== 1'b0) begin
            if (ratio_q.size() == 0) begin
               $display("%0t: ratio expected none, actual %0d", $time, rsp_ratio);
               mismatch_seen = 1'b1;
            end else begin
               due_ratio = ratio_q.pop_front();
               if (rsp_strobe !== 1'b1 || rsp_ratio !== due_ratio) begin
                  $display("%0t: ratio expected %0d, actual %0d (strobe %b)",
                           $time, due_ratio, rsp_ratio, rsp_strobe);
                  mismatch_seen = 1'b1;
               end
            end
         end
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("srgb_contrast_ratio: mismatch");
      $finish;
   end

   initial begin
      color_pair_type pair;
      int unsigned    kind;
      span_type       span;
      for (int code = 0; code < CH_COUNT; code++) begin
         lin_curve[code] = linear_level(code);
      end

      add_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      add_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
      add_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
      add_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      add_pair(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      add_pair(8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0);
      add_pair(8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0);
      add_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0);
      add_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0);
      add_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255);
      // Codes 10 and 11 sit on either side of the knee of the transfer curve.
      add_pair(8'd10, 8'd10, 8'd10, 8'd11, 8'd11, 8'd11);
      add_pair(8'd11, 8'd11, 8'd11, 8'd10, 8'd10, 8'd10);
      add_pair(8'd10, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      add_pair(8'd0, 8'd11, 8'd0, 8'd0, 8'd10, 8'd0);
      add_pair(8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0);
      add_pair(8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255);
      add_pair(8'd128, 8'd64, 8'd200, 8'd128, 8'd64, 8'd200);
      add_pair(8'd170, 8'd85, 8'd170, 8'd85, 8'd170, 8'd85);
      add_pair(8'd85, 8'd170, 8'd85, 8'd170, 8'd85, 8'd170);
      add_pair(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0);

      for (int n = 0; n < NUM_RANDOM; n++) begin
         kind = $urandom_range(0, 9);
         span = (kind == 8) ? SPAN_EDGE : (kind == 9) ? SPAN_KNEE : SPAN_FULL;
         pair.first_red    = pick_channel(span);
         pair.first_green  = pick_channel(span);
         pair.first_blue   = pick_channel(span);
         pair.second_red   = pick_channel(span);
         pair.second_green = pick_channel(span);
         pair.second_blue  = pick_channel(span);
         if (kind == 5 || kind == 6 || kind == 7) begin
            pair.second_red   = pair.first_red;
            pair.second_green = pair.first_green;
            pair.second_blue  = pair.first_blue;
         end
         // Nearly equal colors give ratios just above 1.0.
         if (kind == 7) begin
            case ($urandom_range(0, 2))
               0: pair.second_red   = pair.first_red ^ 8'($urandom_range(1, 3));
               1: pair.second_green = pair.first_green ^ 8'($urandom_range(1, 3));
               default: pair.second_blue = pair.first_blue ^ 8'($urandom_range(1, 3));
            endcase
         end
         pending_q.push_back(pair);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || start) @(posedge clock);
      while (ratio_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (!mismatch_seen && ratio_q.size() == 0) begin
         $display("srgb_contrast_ratio: match");
      end else begin
         $display("srgb_contrast_ratio: mismatch");
      end
      $finish;
   end

endmodule
